// ===== sv/fbfla_pkg.sv =====
// ============================================================================
// fbfla_pkg: shared types and codes for the block free-list allocator
// Operation and status codes, controller states and the result record.
// ============================================================================
package fbfla_pkg;

  // Widths of the request and result fields
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxPortW = 6;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CntPortW = 7;

  // Reset value of the pool_size register
  localparam logic [CntPortW-1:0] BlockCountRst = 7'd64;

  // Request operation codes (code 3 is a no-op)
  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_INIT
  } state_e;

  // One result record as it waits in the output stage
  typedef struct packed {
    logic [IdxPortW-1:0] granted;
    status_e             status;
    logic [CntPortW-1:0] count;
  } result_t;

endpackage

// ===== sv/fixed_block_free_list_allocator_unit.sv =====
// ============================================================================
// fixed_block_free_list_allocator_unit: fixed-size block pool allocator
// Keeps a linked free list of block indices in a link RAM.
// ============================================================================
// Usage:
//   Requests enter on the s_axis channel: tdata[1:0] is the operation
//   (allocate, free, initialize; code 3 is a no-op) and tdata[7:2] the block
//   returned by a free. Each request gives exactly one result on m_axis:
//   granted block, status and the free count after the request.
//   pool_size is written through cfg_we_i / cfg_wdata_i; the user must do
//   so only while idle, which the block does not enforce.
// Flow: free and no-op results are registered on accept; allocate reads
//   the head's link from the registered link RAM port, then registers the
//   result; initialize writes one link per block, n = min(pool_size,
//   NUM_BLOCKS) blocks. One request is worked on at a time; s_axis_tready
//   is low while an allocate or initialize is in progress.
// Reset: the free list is empty (free count 0, head 0) until the first
//   initialize; pool_size resets to 64. The link RAM is not cleared.
// Stall: results queue in a two-entry output stage, so a new request is
//   taken while one result waits; with two waiting, s_axis_tready drops.
// ============================================================================
module fixed_block_free_list_allocator_unit
  import fbfla_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: pool_size
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] operation, [7:2] free_index
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [5:0] granted_index, [7:6] status,
                                      // [14:8] free_count, [15] zero
);

  localparam int unsigned IdxW = $clog2(NUM_BLOCKS);
  localparam int unsigned CntW = $clog2(NUM_BLOCKS + 1);

  // Configuration register
  logic [CntPortW-1:0] blk_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_cnt_q <= BlockCountRst;
    end else if (cfg_we_i) begin
      blk_cnt_q <= cfg_wdata_i;
    end
  end

  // Effective pool size
  logic [CntW-1:0] n_eff;
  assign n_eff = (32'(blk_cnt_q) > NUM_BLOCKS) ? CntW'(NUM_BLOCKS) : CntW'(blk_cnt_q);

  // Request fields
  logic                s_fire;
  logic [OpW-1:0]      req_op;
  logic [IdxPortW-1:0] req_idx;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign req_op  = s_axis_tdata[1:0];
  assign req_idx = s_axis_tdata[7:2];

  // Control state
  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] free_q, free_d;
  logic [IdxW-1:0] ptr_q, ptr_d;

  // Link RAM controls
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [IdxW-1:0] ram_wdata, ram_rdata;

  // Completion of the current request
  logic    done;
  result_t res;

  logic bad_free;
  logic init_last;

  assign bad_free  = (32'(req_idx) >= 32'(n_eff)) || (32'(free_q) >= 32'(n_eff));
  assign init_last = (ptr_q == IdxW'(n_eff - 1'b1));

  fbfla_ram #(
    .WIDTH (IdxW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (req_op == OP_ALLOC) begin
            state_d = S_ALLOC;
          end else if (req_op == OP_INIT && n_eff != '0) begin
            state_d = S_INIT;
          end
        end
      end
      S_ALLOC: state_d = S_IDLE;
      S_INIT: begin
        if (init_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    head_d      = head_q;
    free_d      = free_q;
    ptr_d       = ptr_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = '0;
    ram_raddr   = head_q;
    done        = 1'b0;
    res.granted = '0;
    res.status  = ST_OK;
    res.count   = CntPortW'(free_q);

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          priority if (req_op == OP_ALLOC) begin
            // fetch the head's link; the result is formed in S_ALLOC
            ram_re = (free_q != '0);
          end else if (req_op == OP_FREE) begin
            done = 1'b1;
            if (bad_free) begin
              res.status = ST_BAD_FREE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = IdxW'(req_idx);
              ram_wdata = head_q;
              head_d    = IdxW'(req_idx);
              free_d    = free_q + 1'b1;
              res.count = CntPortW'(free_q + 1'b1);
            end
          end else if (req_op == OP_INIT) begin
            head_d = '0;
            ptr_d  = '0;
            if (n_eff == '0) begin
              free_d    = '0;
              done      = 1'b1;
              res.count = '0;
            end
          end else begin
            // unused code: report current count
            done = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        done = 1'b1;
        if (free_q == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.granted = IdxPortW'(head_q);
          head_d      = ram_rdata;
          free_d      = free_q - 1'b1;
          res.count   = CntPortW'(free_q - 1'b1);
        end
      end
      S_INIT: begin
        // chain block ptr to ptr+1; last link is 0
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = init_last ? '0 : IdxW'(ptr_q + 1'b1);
        ptr_d     = IdxW'(ptr_q + 1'b1);
        if (init_last) begin
          free_d    = n_eff;
          done      = 1'b1;
          res.count = CntPortW'(n_eff);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      free_q  <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      free_q  <= free_d;
      ptr_q   <= ptr_d;
    end
  end

  // Two-entry output stage: result register plus skid register
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (out_vld_q && m_axis_tready) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    if (done) begin
      if (!out_vld_d) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Ports
  assign s_axis_tready = (state_q == S_IDLE) && !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.count, out_q.status, out_q.granted};

endmodule

// ===== sv/fbfla_ram.sv =====
// ============================================================================
// fbfla_ram: simple dual-port RAM with registered read
// One write port and one read port; read data appears in the cycle after re_i.
// ============================================================================
module fbfla_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fbfla_checker.sv =====
// ============================================================================
// fbfla_checker: port-level checks for the block free-list allocator
// Watches the request and result streams; bound to the top level.
// ============================================================================
module fbfla_checker
  import fbfla_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Any failed request grants block 0
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:6] != ST_OK |-> m_axis_tdata[5:0] == '0)
    else $error("failed request carries a granted block");

  // Empty pool reports a zero free count
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:6] == ST_EMPTY |-> m_axis_tdata[14:8] == '0)
    else $error("empty status with nonzero free count");

  // Allocate needs the link read: no request taken in the next cycle
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_ALLOC |=> !s_axis_tready)
    else $error("request taken during allocate");

endmodule

bind fixed_block_free_list_allocator_unit fbfla_checker u_fbfla_checker (.*);
